FILE: hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator: payload
// structs, result codes, register indexes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = 11;
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		RES_OK         = 3'd0,
		RES_EMPTY      = 3'd1,
		RES_MISALIGNED = 3'd2,
		RES_RANGE      = 3'd3,
		RES_DOUBLE     = 3'd4
	} res_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_BASE   = 2'd0,
		REG_BLOCK_SIZE  = 2'd1,
		REG_BLOCK_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic              operation;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   block_address;
		logic [CNT_W-1:0]    in_use;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_ADD,
		S_F_START,
		S_F_DIV,
		S_F_CHK,
		S_F_RD,
		S_DONE
	} fsm_state_t;

	typedef struct packed {
		logic        sweep;
		logic        capture;
		logic        ring_rd;
		logic        alloc_take;
		logic        div_start;
		logic        flag_rd;
		logic        free_push;
		logic        res_we;
		logic        res_use_addr;
		res_status_t res_status;
		logic        out_load;
	} cmd_t;

	typedef struct packed {
		logic cfg_hit;
		logic sweep_done;
		logic pool_empty;
		logic div_busy;
		logic misaligned;
		logic out_of_range;
		logic flag_set;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool manager with a circular free list and per-block
// free flags; allocate returns a block address, free validates and returns
// a block to the list.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. An allocate goes from acceptance to
// result through ring read, multiply of index by block size, base add and
// result load (an empty pool goes straight to the result load). A free runs
// the bit-serial divider that turns the address offset into a block index
// at one quotient bit per cycle, followed by the alignment and range check,
// a flag memory read and the push. After reset and after every write to a
// pool register, a clearing pass rebuilds the free ring and the free flags
// one entry per cycle; req_stall stays high throughout the pass. A finished
// result waits in an output register, so the next request is accepted while
// it is still stalled.
`default_nettype none

module fixed_block_pool_allocator
	import fbpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output rsp_t                       rsp
);

	cmd_t  cmd;
	stat_t stat;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.operation),
		.stat      (stat),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	fbpa_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

`ifndef SYNTHESIS
	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != RES_OK |-> rsp.block_address == '0)
		else $error("failed request returned a nonzero block address");

	a_in_use_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.in_use <= CNT_W'(MAX_BLOCKS))
		else $error("in_use exceeds the pool capacity");

	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_index == REG_POOL_BASE || cfg_index == REG_BLOCK_SIZE
		|| cfg_index == REG_BLOCK_COUNT) |=> req_stall)
		else $error("register write did not start the clearing pass");

	a_empty_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == RES_EMPTY |-> rsp.in_use != '0)
		else $error("pool reported empty with no block in use");
`endif

endmodule

`default_nettype wire

FILE: hdl/fbpa_divider.sv
// ----------------------------------------------------------------------------
// fbpa_divider
// Restoring divider, one quotient bit per cycle: address offset divided by
// the block size, giving quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_divider
	import fbpa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [ADDR_W-1:0] dividend,
	input  wire logic [SIZE_W-1:0] divisor,
	output logic [ADDR_W-1:0]      quotient,
	output logic [SIZE_W-1:0]      remainder,
	output logic                   busy
);

	localparam int STEP_W = $clog2(ADDR_W);

	logic [ADDR_W-1:0] quot_q;
	logic [SIZE_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   diff;
	logic              ge;

	always_comb begin
		trial = {rem_q, quot_q[ADDR_W-1]};
		diff  = trial - {1'b0, divisor};
		ge    = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(ADDR_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[ADDR_W-2:0], ge};
			rem_q  <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
	end

	assign quotient  = quot_q;
	assign remainder = rem_q;
	assign busy      = busy_q;

endmodule

`default_nettype wire

FILE: hdl/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// fbpa_datapath
// Registers, free ring and free flag memories, ring pointers, offset
// divider, address multiply-add and the result register of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_datapath
	import fbpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire req_t                  req,
	input  wire logic                  rsp_stall,
	input  wire cmd_t                  cmd,
	output stat_t                      stat,
	output logic                       rsp_valid,
	output rsp_t                       rsp
);

	localparam int PROD_W = IDX_W + SIZE_W;

	logic [ADDR_W-1:0] pool_base_q;
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]  block_count_q;
	logic [CNT_W-1:0]  n_eff;

	logic [IDX_W-1:0]  head_q;
	logic [IDX_W-1:0]  tail_q;
	logic [IDX_W-1:0]  head_nxt;
	logic [IDX_W-1:0]  tail_nxt;
	logic [CNT_W-1:0]  free_total_q;
	logic [IDX_W-1:0]  sweep_q;

	logic              below_q;
	logic [ADDR_W-1:0] dist_q;
	logic [ADDR_W-1:0] quot;
	logic [SIZE_W-1:0] rem;
	logic              div_busy;
	logic [IDX_W-1:0]  chk_idx;
	logic [IDX_W-1:0]  idx_q;

	logic [IDX_W-1:0]  ring_mem [MAX_BLOCKS];
	logic              flag_mem [MAX_BLOCKS];
	logic [IDX_W-1:0]  ring_rdata_q;
	logic              flag_rdata_q;
	logic              ring_we;
	logic [IDX_W-1:0]  ring_waddr;
	logic [IDX_W-1:0]  ring_wdata;
	logic              flag_we;
	logic [IDX_W-1:0]  flag_waddr;
	logic              flag_wdata;

	logic [PROD_W-1:0]   prod_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic                cfg_hit;

	// Configuration registers
	assign cfg_hit = cfg_we && (cfg_index == REG_POOL_BASE || cfg_index == REG_BLOCK_SIZE
		|| cfg_index == REG_BLOCK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_size_q  <= SIZE_W'(64);
			block_count_q <= CNT_W'(MAX_BLOCKS);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POOL_BASE:   pool_base_q   <= cfg_data[ADDR_W-1:0];
				REG_BLOCK_SIZE:  block_size_q  <= cfg_data[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the block count into 1..MAX_BLOCKS
	always_comb begin
		if (block_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (block_count_q > CNT_W'(MAX_BLOCKS)) begin
			n_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			n_eff = block_count_q;
		end
	end

	// Ring pointers wrap at the effective block count
	always_comb begin
		head_nxt = (CNT_W'(head_q) + CNT_W'(1) == n_eff) ? '0 : head_q + IDX_W'(1);
		tail_nxt = (CNT_W'(tail_q) + CNT_W'(1) == n_eff) ? '0 : tail_q + IDX_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			free_total_q <= CNT_W'(MAX_BLOCKS);
		end else if (cmd.sweep) begin
			head_q       <= '0;
			tail_q       <= '0;
			free_total_q <= n_eff;
		end else if (cmd.alloc_take) begin
			head_q       <= head_nxt;
			free_total_q <= free_total_q - CNT_W'(1);
		end else if (cmd.free_push) begin
			tail_q       <= tail_nxt;
			free_total_q <= free_total_q + CNT_W'(1);
		end
	end

	// Clearing sweep counter; restart on any register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cfg_hit) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + IDX_W'(1);
		end
	end

	// Free request: distance from pool base, then divide
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			below_q <= req.address < pool_base_q;
			dist_q  <= (req.address < pool_base_q) ? pool_base_q - req.address
				: req.address - pool_base_q;
		end
	end

	fbpa_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dist_q),
		.divisor   (block_size_q),
		.quotient  (quot),
		.remainder (rem),
		.busy      (div_busy)
	);

	assign chk_idx = (block_size_q == '0) ? '0 : quot[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.flag_rd) begin
			idx_q <= chk_idx;
		end
	end

	// Memory write port selection
	always_comb begin
		ring_we    = cmd.sweep || cmd.free_push;
		ring_waddr = cmd.sweep ? sweep_q : tail_q;
		ring_wdata = cmd.sweep ? sweep_q : idx_q;
		flag_we    = cmd.sweep || cmd.alloc_take || cmd.free_push;
		flag_wdata = cmd.sweep || cmd.free_push;
		if (cmd.sweep) begin
			flag_waddr = sweep_q;
		end else if (cmd.alloc_take) begin
			flag_waddr = ring_rdata_q;
		end else begin
			flag_waddr = idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[ring_waddr] <= ring_wdata;
		end
		if (cmd.ring_rd) begin
			ring_rdata_q <= ring_mem[head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flag_mem[flag_waddr] <= flag_wdata;
		end
		if (cmd.flag_rd) begin
			flag_rdata_q <= flag_mem[chk_idx];
		end
	end

	// Block address: multiply into prod_q, then add the base
	always_ff @(posedge clk) begin
		if (cmd.alloc_take) begin
			prod_q <= ring_rdata_q * block_size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= cmd.res_use_addr ? pool_base_q + ADDR_W'(prod_q) : '0;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.status        <= res_status_q;
			rsp_q.block_address <= res_addr_q;
			rsp_q.in_use        <= n_eff - free_total_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		stat.cfg_hit      = cfg_hit;
		stat.sweep_done   = sweep_q == IDX_W'(MAX_BLOCKS - 1);
		stat.pool_empty   = free_total_q == '0;
		stat.div_busy     = div_busy;
		stat.misaligned   = (block_size_q == '0) ? (dist_q != '0) : (rem != '0);
		stat.out_of_range = (below_q && dist_q != '0)
			|| (block_size_q != '0 && quot >= ADDR_W'(n_eff));
		stat.flag_set     = flag_rdata_q;
		stat.out_free     = !rsp_valid_q || !rsp_stall;
	end

endmodule

`default_nettype wire

FILE: hdl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Controller of the allocator: clearing sweep, allocate and free sequences,
// result hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl
	import fbpa_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  req_valid,
	input  wire logic  req_op,
	input  wire stat_t stat,
	output logic       req_stall,
	output cmd_t       cmd
);

	fsm_state_t state_q;
	fsm_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		req_stall = state_q != S_IDLE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_done) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					if (req_op == OP_FREE) begin
						state_nxt = S_F_START;
					end else if (stat.pool_empty) begin
						cmd.res_we     = 1'b1;
						cmd.res_status = RES_EMPTY;
						state_nxt      = S_DONE;
					end else begin
						cmd.ring_rd = 1'b1;
						state_nxt   = S_A_RD;
					end
				end
			end
			S_A_RD: begin
				cmd.alloc_take = 1'b1;
				state_nxt      = S_A_ADD;
			end
			S_A_ADD: begin
				cmd.res_we       = 1'b1;
				cmd.res_use_addr = 1'b1;
				cmd.res_status   = RES_OK;
				state_nxt        = S_DONE;
			end
			S_F_START: begin
				cmd.div_start = 1'b1;
				state_nxt     = S_F_DIV;
			end
			S_F_DIV: begin
				if (!stat.div_busy) begin
					state_nxt = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (stat.misaligned) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = RES_MISALIGNED;
					state_nxt      = S_DONE;
				end else if (stat.out_of_range) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = RES_RANGE;
					state_nxt      = S_DONE;
				end else begin
					cmd.flag_rd = 1'b1;
					state_nxt   = S_F_RD;
				end
			end
			S_F_RD: begin
				cmd.res_we = 1'b1;
				if (stat.flag_set) begin
					cmd.res_status = RES_DOUBLE;
				end else begin
					cmd.free_push  = 1'b1;
					cmd.res_status = RES_OK;
				end
				state_nxt = S_DONE;
			end
			S_DONE: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
		// a register write rebuilds the pool
		if (stat.cfg_hit) begin
			state_nxt = S_CLEAR;
		end
	end

endmodule

`default_nettype wire

FILE: verif/fixed_block_pool_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_tb
// Self-checking bench for the block pool allocator. A scoreboard keeps its
// own copy of the free ring, the per-block flags and the pool registers. It
// predicts status, block address and in-use count for every accepted
// request and compares each result against the oldest prediction. Directed
// requests cover alignment, range, double free, empty pool, base wrap and
// zero block size. Random phases follow, each under its own pool setting.
// Both handshake sides idle at random, and one long receiver hold backs up
// the pipeline.
// ----------------------------------------------------------------------------

module fixed_block_pool_allocator_tb
	import fbpa_pkg::*;
();

	localparam int IDLE_LIMIT = 4000;
	localparam int PHASES     = 10;
	localparam int PHASE_REQS = 75;

	class pool_scoreboard;
		bit [ADDR_W-1:0] base;
		bit [SIZE_W-1:0] size;
		bit [CNT_W-1:0]  count;
		bit [IDX_W-1:0]  free_ring [MAX_BLOCKS];
		bit              free_flag [MAX_BLOCKS];
		int unsigned     head;
		int unsigned     tail;
		int unsigned     free_total;
		rsp_t            pool_results [$];
		int              errors;

		function new();
			base   = '0;
			size   = 16'd64;
			count  = CNT_W'(MAX_BLOCKS);
			errors = 0;
			rebuild();
		endfunction

		// Clamp the count register to 1..MAX_BLOCKS.
		function int unsigned blocks();
			if (count == 0) begin
				return 1;
			end
			if (count > MAX_BLOCKS) begin
				return MAX_BLOCKS;
			end
			return count;
		endfunction

		function void rebuild();
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				free_ring[i] = IDX_W'(i);
				free_flag[i] = 1'b1;
			end
			head       = 0;
			tail       = 0;
			free_total = blocks();
		endfunction

		function void write_reg(cfg_reg_t which, bit [CFG_DATA_W-1:0] value);
			case (which)
				REG_POOL_BASE: begin
					base = value;
				end
				REG_BLOCK_SIZE: begin
					size = value[SIZE_W-1:0];
				end
				REG_BLOCK_COUNT: begin
					count = value[CNT_W-1:0];
				end
				default: begin
					return;
				end
			endcase
			rebuild();
		endfunction

		function bit [ADDR_W-1:0] block_addr(int unsigned idx);
			return base + idx * size;
		endfunction

		// Pick a random block that is currently allocated.
		function bit find_used(output int unsigned idx);
			int unsigned n;
			int unsigned start;
			n     = blocks();
			start = $urandom_range(0, n - 1);
			for (int unsigned k = 0; k < n; k++) begin
				idx = (start + k) % n;
				if (!free_flag[idx]) begin
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void take_request(req_t r);
			rsp_t        want;
			int unsigned n;
			int unsigned idx;
			int unsigned delta;
			bit          below;
			bit          bad_align;
			n                  = blocks();
			want.status        = RES_OK;
			want.block_address = '0;
			if (r.operation == OP_ALLOC) begin
				if (free_total == 0) begin
					want.status = RES_EMPTY;
				end else begin
					idx            = free_ring[head];
					free_flag[idx] = 1'b0;
					free_total--;
					head               = (head + 1) % n;
					want.block_address = block_addr(idx);
				end
			end else begin
				below = r.address < base;
				delta = below ? base - r.address : r.address - base;
				idx   = 0;
				if (size == 0) begin
					bad_align = delta != 0;
				end else begin
					bad_align = (delta % size) != 0;
					idx       = delta / size;
				end
				if (bad_align) begin
					want.status = RES_MISALIGNED;
				end else if ((below && delta != 0) || idx >= n) begin
					want.status = RES_RANGE;
				end else if (free_flag[idx]) begin
					want.status = RES_DOUBLE;
				end else begin
					free_ring[tail] = IDX_W'(idx);
					free_flag[idx]  = 1'b1;
					tail            = (tail + 1) % n;
					free_total++;
				end
			end
			want.in_use = CNT_W'(n - free_total);
			pool_results.push_back(want);
		endfunction

		function void report(string field, bit [ADDR_W-1:0] want, bit [ADDR_W-1:0] got);
			errors++;
			$display("%0t: %s expected %h actual %h", $time, field, want, got);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pool_results.size() == 0) begin
				report("unexpected transaction, status", '0, ADDR_W'(got.status));
				return;
			end
			want = pool_results.pop_front();
			if (got.status !== want.status) begin
				report("status", ADDR_W'(want.status), ADDR_W'(got.status));
			end
			if (got.block_address !== want.block_address) begin
				report("block_address", want.block_address, got.block_address);
			end
			if (got.in_use !== want.in_use) begin
				report("in_use", ADDR_W'(want.in_use), ADDR_W'(got.in_use));
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;

	pool_scoreboard sb;
	bit             calm = 1'b0;
	bit             hold_rsp = 1'b0;
	int             idle_cycles = 0;

	fixed_block_pool_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == IDLE_LIMIT) begin
			$display("fixed_block_pool_allocator_tb: FAIL");
			$finish;
		end
	end

	function automatic req_t mk_req(op_t op, bit [ADDR_W-1:0] a);
		req_t r;
		r.operation = op;
		r.address   = a;
		return r;
	endfunction

	function automatic req_t random_request(int alloc_pct);
		req_t        r;
		int unsigned idx;
		int unsigned n;
		int          kind;
		n           = sb.blocks();
		r.operation = OP_ALLOC;
		r.address   = $urandom();
		if ($urandom_range(0, 99) >= alloc_pct) begin
			r.operation = OP_FREE;
			kind        = $urandom_range(0, 9);
			if (kind < 5 && sb.find_used(idx)) begin
				r.address = sb.block_addr(idx);
			end else if (kind < 7) begin
				// free blocks give double frees, indexes past the end give range errors
				r.address = sb.block_addr($urandom_range(0, n + 2));
			end else if (kind == 7) begin
				r.address = sb.block_addr($urandom_range(0, n - 1)) + $urandom_range(1, 3);
			end else if (kind == 8) begin
				r.address = sb.base - sb.size * $urandom_range(1, 4);
			end
		end
		return r;
	endfunction

	task automatic send_req(req_t r);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sb.take_request(r);
	endtask

	// Drop valid, wait out every pending result, then let the block go idle.
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.pool_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic configure(bit [ADDR_W-1:0] b, bit [SIZE_W-1:0] s, bit [CNT_W-1:0] c);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_POOL_BASE;
		cfg_data  <= b;
		@(posedge clk);
		sb.write_reg(REG_POOL_BASE, b);
		cfg_index <= REG_BLOCK_SIZE;
		cfg_data  <= CFG_DATA_W'(s);
		@(posedge clk);
		sb.write_reg(REG_BLOCK_SIZE, CFG_DATA_W'(s));
		cfg_index <= REG_BLOCK_COUNT;
		cfg_data  <= CFG_DATA_W'(c);
		@(posedge clk);
		sb.write_reg(REG_BLOCK_COUNT, CFG_DATA_W'(c));
		cfg_we <= 1'b0;
	endtask

	initial begin : rsp_side
		int wait_cycles;
		rsp_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			wait_cycles = calm ? 0 : $urandom_range(0, 3);
			if (hold_rsp) begin
				hold_rsp    = 1'b0;
				wait_cycles = 400;
			end
			if (wait_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			sb.check_response(rsp);
		end
	end

	initial begin : req_side
		int alloc_pct;
		sb = new();
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_POOL_BASE;
		cfg_data  <= '0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: base 0, 64-byte blocks, full pool
		send_req(mk_req(OP_ALLOC, $urandom()));
		send_req(mk_req(OP_ALLOC, $urandom()));
		send_req(mk_req(OP_FREE, 32'd64));
		send_req(mk_req(OP_FREE, 32'd64));
		send_req(mk_req(OP_FREE, 32'd65));
		send_req(mk_req(OP_FREE, 32'h0001_0000));
		send_req(mk_req(OP_FREE, 32'hFFFF_FFFF));
		send_req(mk_req(OP_FREE, 32'hFFFF_FFC0));

		// two blocks near the top of the address space: empty pool, below base, wrap
		configure(32'hFFFF_FF00, 16'd16, 11'd2);
		send_req(mk_req(OP_ALLOC, 32'hFFFF_FFFF));
		send_req(mk_req(OP_ALLOC, 32'h0));
		send_req(mk_req(OP_ALLOC, $urandom()));
		send_req(mk_req(OP_FREE, 32'hFFFF_FEF0));
		send_req(mk_req(OP_FREE, 32'hFFFF_FEFF));
		send_req(mk_req(OP_FREE, 32'hFFFF_FF10));
		send_req(mk_req(OP_FREE, 32'h0));
		send_req(mk_req(OP_FREE, 32'hFFFF_FF20));
		send_req(mk_req(OP_ALLOC, $urandom()));

		// zero block size, count of zero clamps to one block
		configure(32'h0000_0040, 16'd0, 11'd0);
		send_req(mk_req(OP_ALLOC, $urandom()));
		send_req(mk_req(OP_ALLOC, $urandom()));
		send_req(mk_req(OP_FREE, 32'h0000_0041));
		send_req(mk_req(OP_FREE, 32'h0));
		send_req(mk_req(OP_FREE, 32'h0000_0040));
		send_req(mk_req(OP_FREE, 32'h0000_0040));

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(32'hFFFF_FFFF, 16'hFFFF, 11'd2047);
				1: configure(32'h0, 16'd1, 11'd1);
				2: configure($urandom(), 16'($urandom_range(1, 256)), 11'd1024);
				3: configure($urandom(), 16'd0, 11'($urandom_range(1, 4)));
				9: configure($urandom(), 16'($urandom_range(1, 64)), 11'($urandom_range(0, 2047)));
				default: configure($urandom(),
					($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 128)),
					11'($urandom_range(1, 24)));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			// hold the result side long enough for the request side to back up
			if (phase == 2) begin
				hold_rsp = 1'b1;
			end
			for (int k = 0; k < PHASE_REQS; k++) begin
				// alternate fill and drain so small pools hit empty and refill
				if (k % 15 == 0) begin
					alloc_pct = ((k / 15) % 2 != 0) ? 30 : 75;
				end
				send_req(random_request(alloc_pct));
			end
		end

		settle();
		if (sb.errors == 0) begin
			$display("fixed_block_pool_allocator_tb: PASS");
		end else begin
			$display("fixed_block_pool_allocator_tb: FAIL");
		end
		$finish;
	end

endmodule
